FILE: hdl/tool_holder_box_collision_check_core_assert.svh
// Assertion macros used by the collision check core's checker.
`ifndef TOOL_HOLDER_BOX_COLLISION_CHECK_CORE_ASSERT_SVH
`define TOOL_HOLDER_BOX_COLLISION_CHECK_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define THBC_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define THBC_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: hdl/thbc_pkg.sv
// Package of the tool holder box collision check: constants, types, step functions.
`default_nettype none
package thbc_pkg;

	localparam int LRT_STEPS  = 16;   // root of the squared axis length
	localparam int DIV_STEPS  = 17;   // normalization quotient bits
	localparam int DRT_STEPS  = 27;   // root of the squared clearance
	localparam int PIPE_DEPTH = 3 + LRT_STEPS + 1 + DIV_STEPS + 6 + DRT_STEPS + 1;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOOL_DIAMETER  = 3'd0,
		CFG_FLUTE_LENGTH   = 3'd1,
		CFG_OVERALL_LENGTH = 3'd2,
		CFG_Z_MAX_TRAVEL   = 3'd3,
		CFG_Z_LIMIT_ENABLE = 3'd4
	} cfg_idx_t;

	localparam logic [17:0]        TOOL_DIAMETER_RST  = 18'd10240;
	localparam logic [19:0]        FLUTE_LENGTH_RST   = 20'd20480;
	localparam logic [19:0]        OVERALL_LENGTH_RST = 20'd76800;
	localparam logic signed [21:0] Z_MAX_TRAVEL_RST   = 22'sd0;
	localparam logic               Z_LIMIT_ENABLE_RST = 1'b1;

	localparam logic signed [26:0] FIXTURE_HALF_XY = 27'sd25600;
	localparam logic signed [26:0] FIXTURE_DEPTH   = 27'sd102400;

	localparam logic [15:0] AXIS_ONE     = 16'd16384;   // 1.0 in Q2.14
	localparam logic [36:0] ROUND_HALF   = 37'd8192;
	localparam logic [23:0] CLR_POS_SAT  = 24'h7FFFFF;
	localparam logic [23:0] CLR_NEG_SAT  = 24'h800000;
	localparam logic [26:0] CLR_POS_LIM  = 27'd8388607;
	localparam logic signed [26:0] CLR_NEG_LIM = -27'sd8388608;

	typedef struct packed {
		logic signed [21:0] tip_x;
		logic signed [21:0] tip_y;
		logic signed [21:0] tip_z;
		logic               non_cutting;
	} point_t;

	typedef struct packed {
		point_t             pt;
		logic signed [15:0] ax_x;
		logic signed [15:0] ax_y;
		logic signed [15:0] ax_z;
		logic               axis_short;
	} lpass_t;

	typedef struct packed {
		point_t      pt;
		logic [15:0] den;
		logic [2:0]  neg;
		logic        axis_short;
	} dpass_t;

	typedef struct packed {
		logic               any_pos;
		logic signed [26:0] min_gap;
		logic               coll;
		logic               zhit;
	} cpass_t;

	typedef struct packed {
		logic [31:0] val;
		logic [17:0] rem;
		logic [15:0] res;
	} lsq_t;

	typedef struct packed {
		logic [53:0] val;
		logic [27:0] rem;
		logic [26:0] res;
	} dsq_t;

	typedef struct packed {
		logic [16:0] num;
		logic [15:0] rem;
		logic [16:0] q;
	} dv_t;

	// One digit of the floor square root of the axis length squared.
	function automatic lsq_t lsq_step(lsq_t s);
		logic [19:0] rem2;
		logic [19:0] trial;
		lsq_t        o;
		rem2  = {s.rem, s.val[31:30]};
		trial = {2'b00, s.res, 2'b01};
		o.val = {s.val[29:0], 2'b00};
		if (rem2 >= trial) begin
			o.rem = 18'(rem2 - trial);
			o.res = {s.res[14:0], 1'b1};
		end else begin
			o.rem = rem2[17:0];
			o.res = {s.res[14:0], 1'b0};
		end
		return o;
	endfunction

	// One digit of the floor square root of the clearance squared.
	function automatic dsq_t dsq_step(dsq_t s);
		logic [29:0] rem2;
		logic [29:0] trial;
		dsq_t        o;
		rem2  = {s.rem, s.val[53:52]};
		trial = {1'b0, s.res, 2'b01};
		o.val = {s.val[51:0], 2'b00};
		if (rem2 >= trial) begin
			o.rem = 28'(rem2 - trial);
			o.res = {s.res[25:0], 1'b1};
		end else begin
			o.rem = rem2[27:0];
			o.res = {s.res[25:0], 1'b0};
		end
		return o;
	endfunction

	// One restoring division step.
	function automatic dv_t div_step(dv_t s, logic [15:0] den);
		logic [16:0] rem2;
		dv_t         o;
		rem2  = {s.rem, s.num[16]};
		o.num = {s.num[15:0], 1'b0};
		if (rem2 >= {1'b0, den}) begin
			o.rem = 16'(rem2 - {1'b0, den});
			o.q   = {s.q[15:0], 1'b1};
		end else begin
			o.rem = rem2[15:0];
			o.q   = {s.q[15:0], 1'b0};
		end
		return o;
	endfunction

	// Rounded dividend |a| * 2^14 + len / 2.
	function automatic logic [29:0] norm_num(logic signed [15:0] a, logic [15:0] len);
		logic [15:0] mag;
		mag = a[15] ? 16'(-a) : 16'(a);
		return {mag, 14'b0} + {15'b0, len[15:1]};
	endfunction

	// Tip plus a signed offset.
	function automatic logic signed [25:0] add_off(logic signed [21:0] t, logic [23:0] off,
			logic neg);
		logic signed [25:0] o;
		o = $signed({2'b00, off});
		return 26'(t) + (neg ? -o : o);
	endfunction

	// Larger of the two face gaps along one axis.
	function automatic logic signed [26:0] gap_of(logic signed [25:0] lo,
			logic signed [25:0] hi, logic signed [26:0] fmin, logic signed [26:0] fmax);
		logic signed [26:0] g1;
		logic signed [26:0] g2;
		g1 = fmin - 27'(hi);
		g2 = 27'(lo) - fmax;
		return (g1 > g2) ? g1 : g2;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/tool_holder_box_collision_check_core.sv
// Top level of the tool holder box collision check pipeline.
// One toolpath point enters per cycle while in_ready is high and passes through PIPE_DEPTH
// pipeline stages, most of them taken by the 16-step axis-length square root, the 17-step normalization
// divider and the 27-step clearance square root, each one step per pipeline stage. The
// whole pipeline advances together whenever the output register is empty or its beat is
// taken; while it is held, the first stage still takes a new beat if it is empty. Write
// configuration only while the pipeline is empty: the stages read the live register values.
// cfg_ready is always high, writes to unknown indexes are dropped. The axis is normalized
// (or replaced by +Z when shorter than 0.5), the holder box is built between flute and
// overall length along it and widened in X and Y by 0.75 of the diameter; collision flags
// the Z travel limit or, on cutting moves, a fixture overlap below the tip, and clearance
// gives the signed distance to the fixture block, saturated to 24 bits.
`default_nettype none
module tool_holder_box_collision_check_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [thbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [21:0]                      cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [21:0]               tip_x,
	input  logic signed [21:0]               tip_y,
	input  logic signed [21:0]               tip_z,
	input  logic signed [15:0]               axis_x,
	input  logic signed [15:0]               axis_y,
	input  logic signed [15:0]               axis_z,
	input  logic                             non_cutting,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             collision,
	output logic                             z_limit_hit,
	output logic signed [23:0]               clearance
);
	import thbc_pkg::*;

	// Configuration registers
	logic [17:0]        tool_diameter_q;
	logic [19:0]        flute_length_q;
	logic [19:0]        overall_length_q;
	logic signed [21:0] z_max_travel_q;
	logic               z_limit_enable_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tool_diameter_q  <= TOOL_DIAMETER_RST;
			flute_length_q   <= FLUTE_LENGTH_RST;
			overall_length_q <= OVERALL_LENGTH_RST;
			z_max_travel_q   <= Z_MAX_TRAVEL_RST;
			z_limit_enable_q <= Z_LIMIT_ENABLE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TOOL_DIAMETER:  tool_diameter_q  <= cfg_data[17:0];
				CFG_FLUTE_LENGTH:   flute_length_q   <= cfg_data[19:0];
				CFG_OVERALL_LENGTH: overall_length_q <= cfg_data[19:0];
				CFG_Z_MAX_TRAVEL:   z_max_travel_q   <= cfg_data;
				CFG_Z_LIMIT_ENABLE: z_limit_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pipeline control: advance everything when the output slot frees up, and let the
	// first stage fill a bubble even while the rest is held.
	logic [PIPE_DEPTH-1:0] vld_q;
	logic                  en;
	logic                  ld1;

	assign en        = !vld_q[PIPE_DEPTH-1] || out_ready;
	assign ld1       = en || !vld_q[0];
	assign in_ready  = ld1;
	assign out_valid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld1) begin
				vld_q[0] <= in_valid;
			end
			if (en) begin
				vld_q[PIPE_DEPTH-1:1] <= vld_q[PIPE_DEPTH-2:0];
			end
		end
	end

	// Stage 1: capture the beat
	point_t             pt_s1;
	logic signed [15:0] ax_s1 [3];

	always_ff @(posedge clk) begin
		if (ld1) begin
			pt_s1 <= '{tip_x: tip_x, tip_y: tip_y, tip_z: tip_z, non_cutting: non_cutting};
			ax_s1[0] <= axis_x;
			ax_s1[1] <= axis_y;
			ax_s1[2] <= axis_z;
		end
	end

	// Stage 2: square the axis components
	logic signed [31:0] axsq [3];
	point_t             pt_s2;
	logic signed [15:0] ax_s2 [3];
	logic [30:0]        sq_s2 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			axsq[i] = 32'(ax_s1[i]) * 32'(ax_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s2 <= pt_s1;
			for (int i = 0; i < 3; i++) begin
				ax_s2[i] <= ax_s1[i];
				sq_s2[i] <= axsq[i][30:0];
			end
		end
	end

	// Stage 3: squared length, short-axis test against 0.5^2
	logic [31:0] l2;
	logic [31:0] l2_s3;
	lpass_t      lp_s3;

	assign l2 = 32'(sq_s2[0]) + 32'(sq_s2[1]) + 32'(sq_s2[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			l2_s3 <= l2;
			lp_s3 <= '{pt: pt_s2, ax_x: ax_s2[0], ax_y: ax_s2[1], ax_z: ax_s2[2],
				axis_short: (l2[31:26] == 6'd0)};
		end
	end

	// Axis length root: one result bit per stage
	lsq_t   lrt_init;
	lsq_t   lrt_sk [LRT_STEPS];
	lpass_t lrp_sk [LRT_STEPS];

	assign lrt_init = '{val: l2_s3, rem: '0, res: '0};

	always_ff @(posedge clk) begin
		if (en) begin
			lrt_sk[0] <= lsq_step(lrt_init);
			lrp_sk[0] <= lp_s3;
			for (int k = 1; k < LRT_STEPS; k++) begin
				lrt_sk[k] <= lsq_step(lrt_sk[k-1]);
				lrp_sk[k] <= lrp_sk[k-1];
			end
		end
	end

	// Dividend stage: rounded numerators and divisor (+Z uses a harmless divisor)
	logic [15:0] len;
	lpass_t      lpl;
	logic [29:0] num_sn [3];
	dpass_t      dp_sn;

	assign len = lrt_sk[LRT_STEPS-1].res;
	assign lpl = lrp_sk[LRT_STEPS-1];

	always_ff @(posedge clk) begin
		if (en) begin
			num_sn[0] <= norm_num(lpl.ax_x, len);
			num_sn[1] <= norm_num(lpl.ax_y, len);
			num_sn[2] <= norm_num(lpl.ax_z, len);
			dp_sn <= '{pt: lpl.pt, den: (lpl.axis_short ? AXIS_ONE : len),
				neg: {lpl.ax_z[15], lpl.ax_y[15], lpl.ax_x[15]}, axis_short: lpl.axis_short};
		end
	end

	// Normalization divider: three lanes, one quotient bit per stage. The top
	// dividend bits are always below the divisor, so only 17 steps are needed.
	dv_t    dv_init [3];
	dv_t    dv_sk [DIV_STEPS][3];
	dpass_t dvp_sk [DIV_STEPS];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			dv_init[j] = '{num: num_sn[j][16:0], rem: {3'b000, num_sn[j][29:17]}, q: '0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				dv_sk[0][j] <= div_step(dv_init[j], dp_sn.den);
			end
			dvp_sk[0] <= dp_sn;
			for (int k = 1; k < DIV_STEPS; k++) begin
				for (int j = 0; j < 3; j++) begin
					dv_sk[k][j] <= div_step(dv_sk[k-1][j], dvp_sk[k-1].den);
				end
				dvp_sk[k] <= dvp_sk[k-1];
			end
		end
	end

	// Multiply stage: unit axis magnitude times flute and overall length
	dpass_t      dpl;
	logic [16:0] nm [3];
	point_t      pt_sm;
	logic [2:0]  neg_sm;
	logic [36:0] prf_sm [3];
	logic [36:0] pro_sm [3];

	assign dpl = dvp_sk[DIV_STEPS-1];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			nm[j] = dv_sk[DIV_STEPS-1][j].q;
		end
		if (dpl.axis_short) begin
			nm[0] = '0;
			nm[1] = '0;
			nm[2] = {1'b0, AXIS_ONE};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_sm  <= dpl.pt;
			neg_sm <= dpl.axis_short ? 3'b000 : dpl.neg;
			for (int j = 0; j < 3; j++) begin
				prf_sm[j] <= {20'b0, nm[j]} * {17'b0, flute_length_q};
				pro_sm[j] <= {20'b0, nm[j]} * {17'b0, overall_length_q};
			end
		end
	end

	// Offset stage: round the offsets and add them to the tip
	logic signed [21:0] tipv [3];
	logic [23:0]        offf [3];
	logic [23:0]        offo [3];
	logic signed [25:0] base_sb [3];
	logic signed [25:0] top_sb  [3];
	logic signed [21:0] tipz_sb;
	logic               nc_sb;

	always_comb begin
		tipv[0] = pt_sm.tip_x;
		tipv[1] = pt_sm.tip_y;
		tipv[2] = pt_sm.tip_z;
		for (int j = 0; j < 3; j++) begin
			offf[j] = 24'((prf_sm[j] + ROUND_HALF) >> 14);
			offo[j] = 24'((pro_sm[j] + ROUND_HALF) >> 14);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				base_sb[j] <= add_off(tipv[j], offf[j], neg_sm[j]);
				top_sb[j]  <= add_off(tipv[j], offo[j], neg_sm[j]);
			end
			tipz_sb <= pt_sm.tip_z;
			nc_sb   <= pt_sm.non_cutting;
		end
	end

	// Box stage: order the ends, widen X and Y by the shank radius, test the Z limit
	logic [17:0]        rad;
	logic signed [25:0] rad_s;
	logic signed [25:0] lo [3];
	logic signed [25:0] hi [3];
	logic signed [25:0] bmin_sx [3];
	logic signed [25:0] bmax_sx [3];
	logic               zhit_sx;
	logic               nc_sx;
	logic signed [21:0] tipz_sx;

	assign rad   = 18'(({2'b00, tool_diameter_q} + {1'b0, tool_diameter_q, 1'b0} + 20'd2) >> 2);
	assign rad_s = $signed({8'b0, rad});

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			lo[j] = (base_sb[j] < top_sb[j]) ? base_sb[j] : top_sb[j];
			hi[j] = (base_sb[j] < top_sb[j]) ? top_sb[j] : base_sb[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bmin_sx[0] <= lo[0] - rad_s;
			bmax_sx[0] <= hi[0] + rad_s;
			bmin_sx[1] <= lo[1] - rad_s;
			bmax_sx[1] <= hi[1] + rad_s;
			bmin_sx[2] <= lo[2];
			bmax_sx[2] <= hi[2];
			zhit_sx <= z_limit_enable_q && (top_sb[2] > 26'(z_max_travel_q));
			nc_sx   <= nc_sb;
			tipz_sx <= tipz_sb;
		end
	end

	// Gap stage: per-axis gaps to the fixture block, overlap and collision
	logic               overlap;
	logic signed [26:0] g_sg [3];
	logic               coll_sg;
	logic               zhit_sg;

	assign overlap = (27'(bmin_sx[0]) <= FIXTURE_HALF_XY) && (27'(bmax_sx[0]) >= -FIXTURE_HALF_XY)
		&& (27'(bmin_sx[1]) <= FIXTURE_HALF_XY) && (27'(bmax_sx[1]) >= -FIXTURE_HALF_XY)
		&& (bmin_sx[2] <= 26'sd0) && (27'(bmax_sx[2]) >= -FIXTURE_DEPTH);

	always_ff @(posedge clk) begin
		if (en) begin
			g_sg[0] <= gap_of(bmin_sx[0], bmax_sx[0], -FIXTURE_HALF_XY, FIXTURE_HALF_XY);
			g_sg[1] <= gap_of(bmin_sx[1], bmax_sx[1], -FIXTURE_HALF_XY, FIXTURE_HALF_XY);
			g_sg[2] <= gap_of(bmin_sx[2], bmax_sx[2], -FIXTURE_DEPTH, 27'sd0);
			coll_sg <= zhit_sx || (!nc_sx && overlap && (bmin_sx[2] < 26'(tipz_sx)));
			zhit_sg <= zhit_sx;
		end
	end

	// Square stage: square the positive gaps, find the deepest penetration
	logic [25:0]        gpos [3];
	logic [2:0]         gp_flag;
	logic signed [26:0] m01;
	logic signed [26:0] mgap;
	logic [51:0]        sqg_sq [3];
	cpass_t             cp_sq;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			gp_flag[j] = (g_sg[j] > 27'sd0);
			gpos[j]    = gp_flag[j] ? g_sg[j][25:0] : '0;
		end
		m01  = (g_sg[0] < g_sg[1]) ? g_sg[0] : g_sg[1];
		mgap = (g_sg[2] < m01) ? g_sg[2] : m01;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				sqg_sq[j] <= {26'b0, gpos[j]} * {26'b0, gpos[j]};
			end
			cp_sq <= '{any_pos: |gp_flag, min_gap: mgap, coll: coll_sg, zhit: zhit_sg};
		end
	end

	// Sum stage
	logic [53:0] d2_sd;
	cpass_t      cp_sd;

	always_ff @(posedge clk) begin
		if (en) begin
			d2_sd <= 54'(sqg_sq[0]) + 54'(sqg_sq[1]) + 54'(sqg_sq[2]);
			cp_sd <= cp_sq;
		end
	end

	// Clearance root: one result bit per stage
	dsq_t   drt_init;
	dsq_t   drt_sk [DRT_STEPS];
	cpass_t drp_sk [DRT_STEPS];

	assign drt_init = '{val: d2_sd, rem: '0, res: '0};

	always_ff @(posedge clk) begin
		if (en) begin
			drt_sk[0] <= dsq_step(drt_init);
			drp_sk[0] <= cp_sd;
			for (int k = 1; k < DRT_STEPS; k++) begin
				drt_sk[k] <= dsq_step(drt_sk[k-1]);
				drp_sk[k] <= drp_sk[k-1];
			end
		end
	end

	// Output register: pick distance or penetration and saturate
	logic [26:0]        root;
	cpass_t             cpl;
	logic signed [23:0] clr;
	logic               collision_q;
	logic               z_limit_hit_q;
	logic signed [23:0] clearance_q;

	assign root = drt_sk[DRT_STEPS-1].res;
	assign cpl  = drp_sk[DRT_STEPS-1];

	always_comb begin
		if (cpl.any_pos) begin
			clr = (root > CLR_POS_LIM) ? CLR_POS_SAT : root[23:0];
		end else begin
			clr = (cpl.min_gap < CLR_NEG_LIM) ? CLR_NEG_SAT : cpl.min_gap[23:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			collision_q   <= cpl.coll;
			z_limit_hit_q <= cpl.zhit;
			clearance_q   <= clr;
		end
	end

	assign collision   = collision_q;
	assign z_limit_hit = z_limit_hit_q;
	assign clearance   = clearance_q;

endmodule
`default_nettype wire

FILE: hdl/thbc_chk.sv
// Port-level checker for the collision check core, with its bind.
`default_nettype none
`include "tool_holder_box_collision_check_core_assert.svh"
module thbc_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               collision,
	input logic               z_limit_hit,
	input logic signed [23:0] clearance
);
	// A held result beat keeps its payload
	`THBC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(clearance) && $stable(collision) && $stable(z_limit_hit), "result beat changed while stalled")

	// Z limit hit always counts as a collision
	`THBC_ASSERT_NOW(a_zhit_coll, out_valid && z_limit_hit, collision, "z limit hit without collision")

	// A fixture collision means the box touches the block: no positive clearance
	`THBC_ASSERT_NOW(a_fix_clr, out_valid && collision && !z_limit_hit, clearance[23] || (clearance == 24'sd0), "fixture collision with positive clearance")

	// An empty output slot never blocks the input
	`THBC_ASSERT_NOW(a_in_open, !out_valid, in_ready, "input blocked with empty output")

endmodule

bind tool_holder_box_collision_check_core thbc_chk u_thbc_chk (.*);
`default_nettype wire
